@@ hw/rtl/dstq_pkg.sv @@
package dstq_pkg;

	// operation codes on func
	localparam logic [1:0] FN_INSERT = 2'd0;
	localparam logic [1:0] FN_REMOVE = 2'd1;
	localparam logic [1:0] FN_EXPIRE = 2'd2;

	// result status codes
	localparam logic [1:0] ST_DONE      = 2'd0;
	localparam logic [1:0] ST_FULL      = 2'd1;
	localparam logic [1:0] ST_NOT_FOUND = 2'd2;
	localparam logic [1:0] ST_NONE      = 2'd3;

	localparam int DL_BITS    = 64;
	localparam int TID_BITS   = 8;
	localparam int COUNT_BITS = 7;

endpackage

@@ hw/rtl/dstq_ram.sv @@
module dstq_ram #(
	parameter int WIDTH = 72,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ hw/rtl/deadline_sorted_task_queue.sv @@
// scan: an operation reads at most the count entries held before it (so at most DEPTH),
// insert and a failed expire check stop early, and a no-op, a rejected insert or an
// empty queue reads no entry
// throughput: one operation at a time, set by one read and one write of the entry ram
// per cycle; start is taken again in the cycle that done is shown
// reset: arst_n clears the entry count and all control, entry ram contents are left as is
// results cannot be stalled: done is a single-cycle strobe
module deadline_sorted_task_queue import dstq_pkg::*; #(
	parameter int DEPTH   = 64,
	parameter int ID_BITS = 8
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	output logic                   busy,
	input  logic [1:0]             func,
	input  logic [TID_BITS-1:0]    task_id,
	input  logic [DL_BITS-1:0]     deadline,
	input  logic [DL_BITS-1:0]     now_ticks,
	output logic                   done,
	output logic [1:0]             status,
	output logic                   popped_valid,
	output logic [TID_BITS-1:0]    popped_id,
	output logic [COUNT_BITS-1:0]  entry_count
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int EW = ID_BITS + DL_BITS;

	typedef enum logic {S_IDLE, S_SCAN} state_t;
	typedef enum logic [1:0] {OP_INS, OP_REM, OP_POP, OP_NOP} op_t;

	state_t              state_q;
	op_t                 op_q;
	logic [1:0]          nop_status_q;
	logic [ID_BITS-1:0]  id_q;
	logic [DL_BITS-1:0]  dl_q;
	logic [DL_BITS-1:0]  now_q;
	logic [CW-1:0]       count_q;

	// scan control: read pointer and reads still to issue
	logic [AW-1:0]       rd_ptr_q;
	logic [CW-1:0]       rd_left_q;
	// index of the entry whose read data arrives this cycle
	logic                vld_s1;
	logic [AW-1:0]       idx_s1;
	// insert found its slot, or expire check failed on the head
	logic                stop_q;
	// remove or pop has taken out an entry; later entries move down by one
	logic                found_q;
	logic [ID_BITS-1:0]  pid_q;

	logic                done_q;
	logic [1:0]          status_q;
	logic                pvalid_q;
	logic [TID_BITS-1:0] popped_id_q;

	// entry ram port signals
	logic                rd_en;
	logic [AW-1:0]       rd_addr;
	logic [EW-1:0]       rd_data;
	logic                wr_en;
	logic [AW-1:0]       wr_addr;
	logic [EW-1:0]       wr_data;

	logic [ID_BITS-1:0]  rd_id;
	logic [DL_BITS-1:0]  rd_dl;
	logic                issue;
	logic                proc;
	logic                finish;
	logic                id_hit;
	logic                expired;
	logic                later;

	assign rd_id   = rd_data[EW-1:DL_BITS];
	assign rd_dl   = rd_data[DL_BITS-1:0];
	assign id_hit  = (rd_id == id_q);
	assign expired = (now_q > rd_dl);
	// strictly later deadline moves up; equal ones stay ahead of the new entry
	assign later   = (rd_dl > dl_q);

	dstq_ram #(
		.WIDTH(EW),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (wr_en),
		.waddr(wr_addr),
		.wdata(wr_data),
		.re   (rd_en),
		.raddr(rd_addr),
		.rdata(rd_data)
	);

	// insert scans down from the tail, shifting later entries up one slot;
	// remove and pop scan up from the head, shifting entries after the hit down one.
	// writes never land on a slot that is still to be read, so no forwarding is needed
	always_comb begin
		issue   = 1'b0;
		proc    = 1'b0;
		finish  = 1'b0;
		rd_en   = 1'b0;
		rd_addr = rd_ptr_q;
		wr_en   = 1'b0;
		wr_addr = '0;
		wr_data = {id_q, dl_q};
		if (state_q == S_SCAN) begin
			issue  = (rd_left_q != '0) && !stop_q;
			proc   = vld_s1 && !stop_q;
			finish = stop_q || ((rd_left_q == '0) && !vld_s1);
			rd_en  = issue;
			if (proc) begin
				case (op_q)
					OP_INS: begin
						wr_en   = 1'b1;
						wr_addr = idx_s1 + AW'(1);
						wr_data = later ? rd_data : {id_q, dl_q};
					end
					OP_REM, OP_POP: begin
						if (found_q) begin
							wr_en   = 1'b1;
							wr_addr = idx_s1 - AW'(1);
							wr_data = rd_data;
						end
					end
					default: begin
					end
				endcase
			end
			// every held deadline is later: new entry becomes the head
			if (finish && (op_q == OP_INS) && !stop_q) begin
				wr_en   = 1'b1;
				wr_addr = '0;
				wr_data = {id_q, dl_q};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			op_q         <= OP_NOP;
			nop_status_q <= ST_DONE;
			count_q      <= '0;
			rd_ptr_q     <= '0;
			rd_left_q    <= '0;
			vld_s1       <= 1'b0;
			idx_s1       <= '0;
			stop_q       <= 1'b0;
			found_q      <= 1'b0;
			done_q       <= 1'b0;
			status_q     <= ST_DONE;
			pvalid_q     <= 1'b0;
			popped_id_q  <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						state_q      <= S_SCAN;
						id_q         <= ID_BITS'(task_id);
						dl_q         <= deadline;
						now_q        <= now_ticks;
						stop_q       <= 1'b0;
						found_q      <= 1'b0;
						vld_s1       <= 1'b0;
						nop_status_q <= ST_DONE;
						rd_left_q    <= count_q;
						case (func)
							FN_INSERT: begin
								rd_ptr_q <= AW'(count_q - CW'(1));
								if (count_q == CW'(DEPTH)) begin
									op_q         <= OP_NOP;
									nop_status_q <= ST_FULL;
									rd_left_q    <= '0;
								end else begin
									op_q <= OP_INS;
								end
							end
							FN_REMOVE: begin
								op_q     <= OP_REM;
								rd_ptr_q <= '0;
							end
							FN_EXPIRE: begin
								op_q     <= OP_POP;
								rd_ptr_q <= '0;
							end
							default: begin
								op_q      <= OP_NOP;
								rd_ptr_q  <= '0;
								rd_left_q <= '0;
							end
						endcase
					end
				end
				S_SCAN: begin
					vld_s1 <= issue;
					idx_s1 <= rd_ptr_q;
					if (issue) begin
						rd_left_q <= rd_left_q - CW'(1);
						rd_ptr_q  <= (op_q == OP_INS) ? rd_ptr_q - AW'(1)
						                              : rd_ptr_q + AW'(1);
					end
					if (proc) begin
						case (op_q)
							OP_INS: begin
								if (!later) begin
									stop_q <= 1'b1;
								end
							end
							OP_REM: begin
								if (!found_q && id_hit) begin
									found_q <= 1'b1;
								end
							end
							OP_POP: begin
								// only the head is ever looked at before found or stop
								if (!found_q) begin
									if (expired) begin
										found_q <= 1'b1;
										pid_q   <= rd_id;
									end else begin
										stop_q <= 1'b1;
									end
								end
							end
							default: begin
							end
						endcase
					end
					if (finish) begin
						state_q     <= S_IDLE;
						done_q      <= 1'b1;
						pvalid_q    <= 1'b0;
						popped_id_q <= '0;
						case (op_q)
							OP_INS: begin
								status_q <= ST_DONE;
								count_q  <= count_q + CW'(1);
							end
							OP_REM: begin
								if (found_q) begin
									status_q <= ST_DONE;
									count_q  <= count_q - CW'(1);
								end else begin
									status_q <= ST_NOT_FOUND;
								end
							end
							OP_POP: begin
								if (found_q) begin
									status_q    <= ST_DONE;
									count_q     <= count_q - CW'(1);
									pvalid_q    <= 1'b1;
									popped_id_q <= TID_BITS'(pid_q);
								end else begin
									status_q <= ST_NONE;
								end
							end
							default: begin
								status_q <= nop_status_q;
							end
						endcase
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy         = (state_q != S_IDLE);
	assign done         = done_q;
	assign status       = status_q;
	assign popped_valid = pvalid_q;
	assign popped_id    = popped_id_q;
	// count register is updated on the same edge that raises done
	assign entry_count  = COUNT_BITS'(count_q);

endmodule

@@ hw/rtl/dstq_checker.sv @@
module dstq_checker import dstq_pkg::*; (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  start,
	input logic                  busy,
	input logic                  done,
	input logic [1:0]            status,
	input logic                  popped_valid,
	input logic [TID_BITS-1:0]   popped_id
);

	// an accepted start always leads to a busy cycle
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted transfer did not raise busy");

	// results come one per operation, never back to back
	a_done_gap: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("done strobe on two cycles in a row");

	// a result closes the operation
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("done while still busy");

	// a pop only reports success
	a_pop_status: assert property (@(posedge clk) disable iff (!arst_n)
		done && popped_valid |-> status == ST_DONE)
		else $error("popped entry with failing status");

	// no popped id without a pop
	a_pop_id: assert property (@(posedge clk) disable iff (!arst_n)
		done && !popped_valid |-> popped_id == '0)
		else $error("popped id nonzero without a pop");

endmodule

bind deadline_sorted_task_queue dstq_checker u_dstq_checker (.*);

@@ sim/deadline_sorted_task_queue_test.sv @@
`timescale 1ns / 1ps

module deadline_sorted_task_queue_test;
	import dstq_pkg::*;

	localparam int QUEUE_DEPTH = 64;
	// func code 3 is not an operation, the block only reports its count
	localparam logic [1:0] FN_IDLE = 2'd3;
	// the longest operation plus the longest sender gap stays far under this limit
	localparam int QUIET_LIMIT = 20 * QUEUE_DEPTH;
	localparam int RANDOM_OPS = 1430;
	localparam logic [DL_BITS-1:0] DL_MAX = '1;

	// one result as the block should report it
	typedef struct packed {
		logic [1:0]            status;
		logic                  popped_valid;
		logic [TID_BITS-1:0]   popped_id;
		logic [COUNT_BITS-1:0] entry_count;
	} outcome_t;

	// mirror of the sorted store plus the results still to come
	class task_queue_mirror;
		logic [DL_BITS-1:0]  dl_q[$];
		logic [TID_BITS-1:0] id_q[$];
		outcome_t            awaited_outcomes[$];
		int                  errors;

		function new();
			errors = 0;
		endfunction

		// apply one accepted operation to the mirror and queue its result
		function void apply_op(logic [1:0] op, logic [TID_BITS-1:0] tid,
			logic [DL_BITS-1:0] dl, logic [DL_BITS-1:0] now);
			outcome_t o;
			int pos;
			bit found;
			o = '0;
			found = 0;
			case (op)
				FN_INSERT: begin
					if (dl_q.size() >= QUEUE_DEPTH) begin
						o.status = ST_FULL;
					end else begin
						// ties go behind the entries already there
						pos = 0;
						while (pos < dl_q.size() && dl_q[pos] <= dl)
							pos++;
						dl_q.insert(pos, dl);
						id_q.insert(pos, tid);
						o.status = ST_DONE;
					end
				end
				FN_REMOVE: begin
					o.status = ST_NOT_FOUND;
					for (int i = 0; i < id_q.size() && !found; i++) begin
						if (id_q[i] == tid) begin
							dl_q.delete(i);
							id_q.delete(i);
							o.status = ST_DONE;
							found = 1;
						end
					end
				end
				FN_EXPIRE: begin
					// expiry needs the time strictly past the earliest deadline
					if (dl_q.size() == 0 || now <= dl_q[0]) begin
						o.status = ST_NONE;
					end else begin
						o.status = ST_DONE;
						o.popped_valid = 1'b1;
						o.popped_id = id_q[0];
						void'(dl_q.pop_front());
						void'(id_q.pop_front());
					end
				end
				default: begin
					o.status = ST_DONE;
				end
			endcase
			o.entry_count = COUNT_BITS'(dl_q.size());
			awaited_outcomes.push_back(o);
		endfunction

		// compare one reported result with the oldest one awaited
		function void check_result(logic [1:0] st, logic pv, logic [TID_BITS-1:0] pid,
			logic [COUNT_BITS-1:0] cnt);
			outcome_t o;
			if (awaited_outcomes.size() == 0) begin
				$error("result with no operation outstanding");
				errors++;
				return;
			end
			o = awaited_outcomes.pop_front();
			if (st !== o.status) begin
				$error("status expected %0d got %0d", o.status, st);
				errors++;
			end
			if (pv !== o.popped_valid) begin
				$error("popped_valid expected %0d got %0d", o.popped_valid, pv);
				errors++;
			end
			if (pid !== o.popped_id) begin
				$error("popped_id expected %0d got %0d", o.popped_id, pid);
				errors++;
			end
			if (cnt !== o.entry_count) begin
				$error("entry_count expected %0d got %0d", o.entry_count, cnt);
				errors++;
			end
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  start;
	logic                  busy;
	logic [1:0]            func;
	logic [TID_BITS-1:0]   task_id;
	logic [DL_BITS-1:0]    deadline;
	logic [DL_BITS-1:0]    now_ticks;
	logic                  done;
	logic [1:0]            status;
	logic                  popped_valid;
	logic [TID_BITS-1:0]   popped_id;
	logic [COUNT_BITS-1:0] entry_count;

	task_queue_mirror mirror;
	int quiet_cycles;
	bit calm;

	deadline_sorted_task_queue #(
		.DEPTH   (QUEUE_DEPTH),
		.ID_BITS (TID_BITS)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.func         (func),
		.task_id      (task_id),
		.deadline     (deadline),
		.now_ticks    (now_ticks),
		.done         (done),
		.status       (status),
		.popped_valid (popped_valid),
		.popped_id    (popped_id),
		.entry_count  (entry_count)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// result check first, then the transfer of this edge: a result shown in the
	// cycle a new operation is taken belongs to the previous one
	always @(posedge clk) begin
		if (arst_n) begin
			if (done)
				mirror.check_result(status, popped_valid, popped_id, entry_count);
			if (start && !busy)
				mirror.apply_op(func, task_id, deadline, now_ticks);
			if (done || (start && !busy))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			// hung block: nothing taken and nothing reported for too long
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("FAILURE");
				$finish;
			end
		end
	end

	// present one operation at a falling edge and hold it until the transfer
	task send_op(input logic [1:0] op, input logic [TID_BITS-1:0] tid,
		input logic [DL_BITS-1:0] dl, input logic [DL_BITS-1:0] now);
		func <= op;
		task_id <= tid;
		deadline <= dl;
		now_ticks <= now;
		start <= 1'b1;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		@(negedge clk);
		// random gap on the sender side, with noise on the idle fields
		if (!calm && $urandom_range(0, 99) < 25) begin
			start <= 1'b0;
			func <= 2'($urandom);
			task_id <= TID_BITS'($urandom);
			deadline <= {$urandom, $urandom};
			now_ticks <= {$urandom, $urandom};
			repeat ($urandom_range(1, 6))
				@(negedge clk);
		end
	endtask

	initial begin
		logic [1:0]          op;
		logic [TID_BITS-1:0] tid;
		logic [DL_BITS-1:0]  dl;
		logic [DL_BITS-1:0]  now;
		logic [DL_BITS-1:0]  head;
		logic [DL_BITS-1:0]  base_tick;
		int insert_pct;
		int r;

		mirror = new();
		quiet_cycles = 0;
		calm = 0;
		arst_n = 1'b0;
		start = 1'b0;
		func = FN_INSERT;
		task_id = '0;
		deadline = '0;
		now_ticks = '0;
		repeat (8)
			@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// empty queue: nothing to expire, nothing to remove, idle code
		send_op(FN_EXPIRE, 8'd0, 64'd0, DL_MAX);
		send_op(FN_REMOVE, 8'd0, 64'd0, 64'd0);
		send_op(FN_IDLE, 8'd0, 64'd0, 64'd0);
		// extremes of id and deadline, ties, duplicate ids
		send_op(FN_INSERT, 8'd255, DL_MAX, 64'd0);
		send_op(FN_INSERT, 8'd0, 64'd0, 64'd0);
		send_op(FN_INSERT, 8'd7, 64'd100, 64'd0);
		send_op(FN_INSERT, 8'd9, 64'd100, 64'd0);
		send_op(FN_INSERT, 8'd7, 64'd50, 64'd0);
		send_op(FN_INSERT, 8'd5, 64'd100, 64'd0);
		// duplicate id: only the earliest one goes
		send_op(FN_REMOVE, 8'd7, 64'd0, 64'd0);
		send_op(FN_REMOVE, 8'd200, 64'd0, 64'd0);
		// expiry needs strictly greater time
		send_op(FN_EXPIRE, 8'd0, 64'd0, 64'd0);
		send_op(FN_EXPIRE, 8'd0, 64'd0, 64'd1);
		send_op(FN_EXPIRE, 8'd0, 64'd0, 64'd100);
		// equal deadlines come out in insertion order
		send_op(FN_EXPIRE, 8'd0, 64'd0, 64'd101);
		send_op(FN_EXPIRE, 8'd0, 64'd0, 64'd101);
		send_op(FN_IDLE, 8'hff, DL_MAX, DL_MAX);
		send_op(FN_EXPIRE, 8'd0, 64'd0, DL_MAX);
		// the maximum deadline can never expire
		send_op(FN_EXPIRE, 8'd0, 64'd0, DL_MAX);
		send_op(FN_REMOVE, 8'd255, 64'd0, 64'd0);
		send_op(FN_INSERT, 8'haa, 64'haaaa_aaaa_aaaa_aaaa, 64'h5555_5555_5555_5555);
		send_op(FN_INSERT, 8'h55, 64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa);
		send_op(FN_REMOVE, 8'h55, 64'd0, 64'd0);
		send_op(FN_REMOVE, 8'haa, 64'd0, 64'd0);

		// random part in segments: filling ones run the queue into full
		base_tick = {$urandom_range(0, 255), $urandom};
		for (int n = 0; n < RANDOM_OPS; n++) begin
			case ((n / 120) % 6)
				0, 1, 4: insert_pct = 85;
				2, 5:    insert_pct = 15;
				default: insert_pct = 50;
			endcase
			// a long stretch without sender gaps
			calm = (n >= 600 && n < 800);
			base_tick = base_tick + $urandom_range(0, 4);

			r = $urandom_range(0, 99);
			if (r < insert_pct)
				op = FN_INSERT;
			else if (r < insert_pct + (100 - insert_pct) * 45 / 100)
				op = FN_REMOVE;
			else if (r < insert_pct + (100 - insert_pct) * 90 / 100)
				op = FN_EXPIRE;
			else
				op = FN_IDLE;

			tid = TID_BITS'($urandom);
			dl = {$urandom, $urandom};
			now = {$urandom, $urandom};

			if (op == FN_INSERT) begin
				// a small id pool makes duplicates common
				if ($urandom_range(0, 99) < 70)
					tid = TID_BITS'($urandom_range(0, 15));
				case ($urandom_range(0, 9))
					0, 1, 2, 3, 4: dl = base_tick + $urandom_range(0, 30);
					5:             dl = 64'd0;
					6:             dl = DL_MAX;
					7: begin
						// exact tie with an entry already held
						if (mirror.dl_q.size() > 0)
							dl = mirror.dl_q[$urandom_range(0, mirror.dl_q.size() - 1)];
					end
					default: ;
				endcase
			end else if (op == FN_REMOVE) begin
				if (mirror.id_q.size() > 0 && $urandom_range(0, 99) < 70)
					tid = mirror.id_q[$urandom_range(0, mirror.id_q.size() - 1)];
			end else if (op == FN_EXPIRE) begin
				// mostly around the earliest deadline
				if (mirror.dl_q.size() > 0) begin
					head = mirror.dl_q[0];
					case ($urandom_range(0, 7))
						0: now = head - 1;
						1: now = head;
						2: now = head + 1;
						3, 4: now = head + $urandom_range(2, 40);
						5: now = 64'd0;
						6: now = DL_MAX;
						default: ;
					endcase
				end else if ($urandom_range(0, 1) == 0) begin
					now = base_tick;
				end
			end
			send_op(op, tid, dl, now);
		end
		start <= 1'b0;

		// drain, then a tail long enough for the slowest operation
		while (mirror.awaited_outcomes.size() != 0)
			@(posedge clk);
		repeat (QUEUE_DEPTH + 8)
			@(posedge clk);

		if (mirror.errors == 0 && mirror.awaited_outcomes.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
